// ===== hw/rtl/crbfw_pkg.sv =====
package crbfw_pkg;

	localparam int CANVAS_WIDTH_DEF  = 320;
	localparam int CANVAS_HEIGHT_DEF = 172;

	localparam int PIXEL_W     = 16;
	localparam int ADDR_W      = 16;
	localparam int ORIGIN_W    = 16;
	localparam int SIZE_W      = 12;
	localparam int POS_W       = ORIGIN_W + 1;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_RECT_WIDTH  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_RECT_HEIGHT = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_FILL_MODE   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_FILL_COLOUR = 3'd5;

	typedef struct packed {
		logic [ORIGIN_W-1:0] origin_x;
		logic [ORIGIN_W-1:0] origin_y;
		logic [SIZE_W-1:0]   rect_width;
		logic [SIZE_W-1:0]   rect_height;
		logic                fill_mode;
		logic [PIXEL_W-1:0]  fill_colour;
	} cfg_t;

	// px and py are two's complement, sign in the top bit
	typedef struct packed {
		logic [POS_W-1:0]   px;
		logic [POS_W-1:0]   py;
		logic               empty;
		logic               done;
		logic [PIXEL_W-1:0] pixel;
	} pos_t;

endpackage

// ===== hw/rtl/crbfw_walk.sv =====
module crbfw_walk
	import crbfw_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [PIXEL_W-1:0] in_pixel,
	output logic               out_valid,
	input  logic               out_ready,
	output pos_t               out_pos
);

	logic [SIZE_W-1:0] column_count_q;
	logic [SIZE_W-1:0] row_count_q;
	logic              valid_s1;
	pos_t              pos_s1;
	pos_t              pos_next;
	logic              accept;
	logic              empty;
	logic              row_end;
	logic              rect_end;

	assign in_ready = !valid_s1 || out_ready;
	assign accept   = in_valid && in_ready;

	assign empty    = (cfg.rect_width == '0) || (cfg.rect_height == '0);
	assign row_end  = column_count_q >= (cfg.rect_width - SIZE_W'(1));
	assign rect_end = row_end && (row_count_q >= (cfg.rect_height - SIZE_W'(1)));

	always_comb begin
		pos_next.px    = {cfg.origin_x[ORIGIN_W-1], cfg.origin_x}
			+ {{(POS_W-SIZE_W){1'b0}}, column_count_q};
		pos_next.py    = {cfg.origin_y[ORIGIN_W-1], cfg.origin_y}
			+ {{(POS_W-SIZE_W){1'b0}}, row_count_q};
		pos_next.empty = empty;
		pos_next.done  = empty || rect_end;
		pos_next.pixel = in_pixel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			row_count_q    <= '0;
		end else if (accept) begin
			if (empty || row_end) begin
				column_count_q <= '0;
			end else begin
				column_count_q <= column_count_q + SIZE_W'(1);
			end
			if (empty || rect_end) begin
				row_count_q <= '0;
			end else if (row_end) begin
				row_count_q <= row_count_q + SIZE_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1 <= pos_next;
		end
	end

	assign out_valid = valid_s1;
	assign out_pos   = pos_s1;

	a_empty_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && empty |=> column_count_q == '0 && row_count_q == '0)
		else $error("counters not cleared on empty rectangle");

	a_done_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		accept && pos_next.done |=> column_count_q == '0 && row_count_q == '0)
		else $error("counters not returned to zero at end of rectangle");

	a_empty_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && pos_s1.empty |-> pos_s1.done)
		else $error("empty rectangle position without done");

endmodule

// ===== hw/rtl/crbfw_clip.sv =====
module crbfw_clip
	import crbfw_pkg::*;
#(
	parameter int CANVAS_WIDTH  = CANVAS_WIDTH_DEF,
	parameter int CANVAS_HEIGHT = CANVAS_HEIGHT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  pos_t                       in_pos,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [PIXEL_W+ADDR_W-1:0]  out_data,
	output logic                       out_user,
	output logic                       out_last
);

	localparam int COORD_W = 12;
	localparam int MUL_W   = COORD_W + 1;
	localparam int PROD_W  = COORD_W + MUL_W;
	localparam logic [POS_W-1:0] W_LIM = POS_W'(CANVAS_WIDTH);
	localparam logic [POS_W-1:0] H_LIM = POS_W'(CANVAS_HEIGHT);
	localparam logic [MUL_W-1:0] H_MUL = MUL_W'(CANVAS_HEIGHT);

	logic                      valid_s2;
	logic [PIXEL_W+ADDR_W-1:0] data_s2;
	logic                      user_s2;
	logic                      last_s2;
	logic                      accept;
	logic                      on_canvas;
	logic [PROD_W-1:0]         addr_full;
	logic [PIXEL_W-1:0]        pixel;

	assign in_ready = !valid_s2 || out_ready;
	assign accept   = in_valid && in_ready;

	assign on_canvas = !in_pos.empty
		&& !in_pos.px[POS_W-1] && (in_pos.px < W_LIM)
		&& !in_pos.py[POS_W-1] && (in_pos.py < H_LIM);

	assign addr_full = {{MUL_W{1'b0}}, in_pos.px[COORD_W-1:0]} * {{COORD_W{1'b0}}, H_MUL}
		+ {{MUL_W{1'b0}}, in_pos.py[COORD_W-1:0]};

	assign pixel = cfg.fill_mode ? cfg.fill_colour : in_pos.pixel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			user_s2 <= on_canvas;
			last_s2 <= in_pos.done;
			if (on_canvas) begin
				data_s2 <= {pixel, addr_full[ADDR_W-1:0]};
			end else begin
				data_s2 <= '0;
			end
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;
	assign out_user  = user_s2;
	assign out_last  = last_s2;

	a_clipped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !user_s2 |-> data_s2 == '0)
		else $error("clipped position carries non-zero data");

	a_empty_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_pos.empty |=> !user_s2 && last_s2)
		else $error("empty rectangle produced a write or missed done");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ready |=> valid_s2 && $stable(data_s2) && $stable(last_s2))
		else $error("stalled result lost");

endmodule

// ===== hw/rtl/clipped_rect_blit_fill_writer.sv =====
// Results are registered in the walk stage, then the clip stage, before reaching the m_ side.
// Throughput: one transaction per cycle from the two-stage position and clip pipeline, unless m_tready stalls.
// A result waiting on m_tready does not block the next input while stage one is free.
// Reset (arst_n low, asynchronous): configuration registers, rectangle counters
// and all valid flags clear to zero; no clearing pass is needed.
module clipped_rect_blit_fill_writer
	import crbfw_pkg::*;
#(
	parameter int CANVAS_WIDTH  = CANVAS_WIDTH_DEF,
	parameter int CANVAS_HEIGHT = CANVAS_HEIGHT_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [PIXEL_W-1:0]        s_tdata,  // [15:0] source_pixel
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [PIXEL_W+ADDR_W-1:0] m_tdata,  // [15:0] canvas_address, [31:16] write_pixel
	output logic                      m_tuser,  // [0] write_enable
	output logic                      m_tlast   // rect_done
);

	cfg_t cfg_q;
	logic pos_valid;
	logic pos_ready;
	pos_t pos;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ORIGIN_X:    cfg_q.origin_x    <= cfg_data;
				REG_ORIGIN_Y:    cfg_q.origin_y    <= cfg_data;
				REG_RECT_WIDTH:  cfg_q.rect_width  <= cfg_data[SIZE_W-1:0];
				REG_RECT_HEIGHT: cfg_q.rect_height <= cfg_data[SIZE_W-1:0];
				REG_FILL_MODE:   cfg_q.fill_mode   <= cfg_data[0];
				REG_FILL_COLOUR: cfg_q.fill_colour <= cfg_data;
				default: ;
			endcase
		end
	end

	crbfw_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_pixel  (s_tdata),
		.out_valid (pos_valid),
		.out_ready (pos_ready),
		.out_pos   (pos)
	);

	crbfw_clip #(
		.CANVAS_WIDTH  (CANVAS_WIDTH),
		.CANVAS_HEIGHT (CANVAS_HEIGHT)
	) u_clip (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (pos_valid),
		.in_ready  (pos_ready),
		.in_pos    (pos),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_user  (m_tuser),
		.out_last  (m_tlast)
	);

endmodule
